### design/wevd_pkg.sv
// Shared constants of the windowed energy voice detector.
`timescale 1ns / 1ps
package wevd_pkg;

  // Window length default.
  localparam int WINDOW_LEN_DEFAULT = 256;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_SQUARED = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_FRAMES       = 8'd1;

  // Register widths and reset values (1600 squared, hold of three frames).
  localparam int THR_W  = 31;
  localparam int HOLD_W = 8;
  localparam logic [THR_W-1:0]  THRESHOLD_SQUARED_RESET = 31'd2560000;
  localparam logic [HOLD_W-1:0] HOLD_FRAMES_RESET       = 8'd3;

  // Item payload widths.
  localparam int SAMPLE_W  = 16;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 8;

endpackage

### design/windowed_energy_voice_detector_core.sv
// Top level of the windowed energy voice detector: window energy test with frame hold.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+--------------------------------------
//  s_*      | in        | s_tvalid / s_tready       | tdata: sample; tlast: last;
//           |           |                           | tuser: past_end
//  m_*      | out       | m_tvalid / m_tready       | tdata: mouth_open, above_threshold
//  cfg_*    | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// The block accepts one item per cycle when the output side keeps up. An item passes an
// input register, a squaring stage and an accumulate stage, which registers the result of
// the item that closes its frame; the 17 by 17 bit squarer in one stage, and
// the energy add beside the threshold times count product in the next, set the cycle time.
// Reset is synchronous and clears all control state, the window accumulator and the hold
// state. A stalled output only holds items that end a frame; items inside a frame keep
// flowing into the accumulator behind a full output register. Configuration writes are
// always accepted.
module windowed_energy_voice_detector_core #(
  parameter int WINDOW_LEN = wevd_pkg::WINDOW_LEN_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wevd_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] sample (signed)
  input  logic                              s_tlast,   // last sample of the window
  input  logic                              s_tuser,   // [0] past_end
  // Result items.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wevd_pkg::OUT_DATA_W-1:0]   m_tdata,   // [0] mouth_open, [1] above_threshold
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wevd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wevd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wevd_pkg::*;

  // Count width holds WINDOW_LEN itself. The energy sum holds WINDOW_LEN squares of at
  // most 2**30, and the limit holds threshold_squared times the count.
  localparam int CW = $clog2(WINDOW_LEN + 1);
  localparam int EW = 30 + CW;
  localparam int PW = THR_W + CW;
  localparam logic [CW-1:0] WIN = CW'(WINDOW_LEN);

  // Configuration registers.
  logic [THR_W-1:0]  threshold_squared;
  logic [HOLD_W-1:0] hold_frames;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_squared <= THRESHOLD_SQUARED_RESET;
      hold_frames       <= HOLD_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD_SQUARED: threshold_squared <= cfg_data[THR_W-1:0];
        REG_HOLD_FRAMES:       hold_frames       <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one: input register.
  logic                v1;
  logic [SAMPLE_W-1:0] sample1;
  logic                last1;
  logic                past1;

  // Stage two: squared sample.
  logic                v2;
  logic                last2;
  logic                past2;
  logic [30:0]         sq2;

  // Output register.
  logic                ov;
  logic                mouth_open;
  logic                above_threshold;

  // Window and hold state.
  logic [EW-1:0]       energy_sum;
  logic [CW-1:0]       sample_count;
  logic                held_state;
  logic [HOLD_W-1:0]   hold_counter;

  // Flow control: an item that ends a frame needs room in the output register, any
  // other item retires into the accumulator at once.
  logic out_free;
  logic ends_frame;
  logic exec_fire;
  logic s2_ready;
  logic s1_ready;

  assign out_free   = !ov || m_tready;
  assign ends_frame = last2 || past2;
  assign exec_fire  = v2 && (!ends_frame || out_free);
  assign s2_ready   = !v2 || exec_fire;
  assign s1_ready   = !v1 || s2_ready;
  assign s_tready   = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      sample1 <= s_tdata[SAMPLE_W-1:0];
      last1   <= s_tlast;
      past1   <= s_tuser;
    end
  end

  // Magnitude of the sample is at most 32768, so its square fits in 31 bits.
  logic [16:0] mag1;
  logic [30:0] sq1;

  always_comb begin
    mag1 = sample1[SAMPLE_W-1] ? (17'd0 - {1'b1, sample1}) : {1'b0, sample1};
    sq1  = {14'd0, mag1} * {14'd0, mag1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_ready) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && v1) begin
      last2 <= last1;
      past2 <= past1;
      sq2   <= sq1;
    end
  end

  // Stage three: accumulate, decide and apply the hold.
  logic                 in_window;
  logic [EW-1:0]        energy_add;
  logic [CW-1:0]        count_add;
  logic [PW-1:0]        limit;
  logic                 desired;
  logic [HOLD_W-1:0]    hold_inc;
  logic [EW-1:0]        energy_sum_next;
  logic [CW-1:0]        sample_count_next;
  logic                 held_state_next;
  logic [HOLD_W-1:0]    hold_counter_next;

  always_comb begin
    in_window  = sample_count < WIN;
    energy_add = in_window ? (energy_sum + EW'(sq2)) : energy_sum;
    count_add  = in_window ? (sample_count + 1'b1) : sample_count;
    // The mean square beats the threshold when the sum beats threshold times count,
    // using the threshold as it stands when the frame closes.
    limit      = PW'(threshold_squared) * PW'(count_add);
    desired    = PW'(energy_add) > limit;
    hold_inc   = (hold_counter == '1) ? hold_counter : hold_counter + 1'b1;

    energy_sum_next   = energy_add;
    sample_count_next = count_add;
    held_state_next   = held_state;
    hold_counter_next = hold_counter;

    if (past2) begin
      // Beyond the clip: frame closes, state forced closed, counter kept.
      energy_sum_next   = '0;
      sample_count_next = '0;
      held_state_next   = 1'b0;
    end else if (last2) begin
      energy_sum_next   = '0;
      sample_count_next = '0;
      if (desired != held_state) begin
        if (hold_inc >= hold_frames) begin
          held_state_next   = desired;
          hold_counter_next = '0;
        end else begin
          hold_counter_next = hold_inc;
        end
      end else begin
        hold_counter_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum   <= '0;
      sample_count <= '0;
      held_state   <= 1'b0;
      hold_counter <= '0;
    end else if (exec_fire) begin
      energy_sum   <= energy_sum_next;
      sample_count <= sample_count_next;
      held_state   <= held_state_next;
      hold_counter <= hold_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (exec_fire && ends_frame) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && ends_frame) begin
      mouth_open      <= held_state_next;
      above_threshold <= desired && !past2;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, above_threshold, mouth_open};

  // The window count never runs past the window length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= WIN)
    else $error("sample count beyond window length");

  // The held state only moves when an item retires.
  a_held_moves_on_fire: assert property (@(posedge clk) disable iff (rst)
    !exec_fire |=> $stable(held_state))
    else $error("held state changed without a retiring item");

  // A past-end item leaves a closed state and an empty window.
  a_past_end_closes: assert property (@(posedge clk) disable iff (rst)
    exec_fire && past2 |=> !held_state && energy_sum == '0 && sample_count == '0)
    else $error("past-end item did not close the window");

  // A flip of the held state restarts the hold counter.
  a_flip_clears_counter: assert property (@(posedge clk) disable iff (rst)
    exec_fire && last2 && !past2 && held_state_next != held_state |=> hold_counter == '0)
    else $error("hold counter not cleared on flip");

  // A new result only enters when the output register has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    exec_fire && ends_frame |-> !ov || m_tready)
    else $error("result overwritten while stalled");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the windowed energy voice detector core.
`timescale 1ns / 1ps
module tb_top;
  import wevd_pkg::*;

  // Cycles to let the pipeline settle once no result is outstanding.
  localparam int IDLE_SETTLE  = 8;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 24;
  localparam int WIN_ITEMS    = WINDOW_LEN_DEFAULT;

  typedef struct packed {
    logic mouth_open;
    logic above_threshold;
  } level_t;

  typedef enum int {SK_ZERO, SK_NEAR, SK_FULL, SK_EXTREME, SK_CONST} sample_kind_e;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   s_tlast;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predicted state of the detector.
  logic [THR_W-1:0]  energy_limit;
  logic [HOLD_W-1:0] hold_need;
  logic [38:0]       window_energy;
  logic [8:0]        window_count;
  logic              held_open;
  logic [7:0]        hold_run;

  level_t expected_levels[$];
  int     mismatch_count = 0;
  bit     tx_burst = 1'b0;

  windowed_energy_voice_detector_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  // Advances the predicted window and hold state by one accepted item and
  // queues the level that the block must report, if the item ends a frame.
  task automatic track_item(input logic [15:0] smp, input logic lst, input logic pend);
    logic [16:0] mag;
    logic        want;
    level_t      lv;
    if (pend) begin
      // Past the end of the clip: report closed and drop the partial window.
      held_open     = 1'b0;
      window_energy = '0;
      window_count  = '0;
      lv.mouth_open      = 1'b0;
      lv.above_threshold = 1'b0;
      expected_levels.push_back(lv);
    end else begin
      if (window_count < 9'(WIN_ITEMS)) begin
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        window_energy = window_energy + 39'(mag) * 39'(mag);
        window_count  = window_count + 9'd1;
      end
      if (lst) begin
        want = (window_count != 0) &&
               (64'(window_energy) > 64'(energy_limit) * 64'(window_count));
        if (want != held_open) begin
          if (hold_run < 8'd255) hold_run = hold_run + 8'd1;
          if (hold_run >= hold_need) begin
            held_open = want;
            hold_run  = '0;
          end
        end else begin
          hold_run = '0;
        end
        window_energy = '0;
        window_count  = '0;
        lv.mouth_open      = held_open;
        lv.above_threshold = want;
        expected_levels.push_back(lv);
      end
    end
  endtask

  task automatic send_item(input logic [15:0] smp, input logic lst, input logic pend);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    s_tuser  <= pend;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_item(smp, lst, pend);
  endtask

  // Stops sending and waits until every predicted result has come out and
  // any frame still in the pipeline has settled.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Keeps cfg_valid high so back-to-back writes need no gap; cfg_done drops it.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_THRESHOLD_SQUARED) begin
      energy_limit = val[THR_W-1:0];
    end else if (idx == REG_HOLD_FRAMES) begin
      hold_need = val[HOLD_W-1:0];
    end
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  // A sample whose magnitude lies within about an eighth of the given level.
  function automatic logic [15:0] near_sample(input int level);
    int lo;
    int hi;
    int m;
    lo = level - level / 8;
    hi = level + level / 8 + 1;
    if (hi > 32768) hi = 32768;
    m = $urandom_range(hi, lo);
    if ($urandom_range(0, 1) == 1) m = -m;
    if (m == 32768) m = 32767;
    return m[15:0];
  endfunction

  // Runs on the reset values: threshold edge, hold of three frames, past end
  // inside and outside a frame, past end over last.
  task automatic test_reset_levels();
    send_item(16'd1600, 1'b1, 1'b0);
    send_item(16'd1601, 1'b1, 1'b0);
    send_item(16'(-1601), 1'b1, 1'b0);
    send_item(16'h8000, 1'b0, 1'b0);
    send_item(16'h7FFF, 1'b1, 1'b0);
    send_item(16'd0, 1'b1, 1'b0);
    wait_idle();
    send_item(16'h1234, 1'b0, 1'b1);
    send_item(16'h7FFF, 1'b1, 1'b0);
    send_item(16'd100, 1'b0, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b1);
    send_item(16'd5, 1'b0, 1'b0);
    send_item(16'(-5), 1'b0, 1'b0);
    send_item(16'd0, 1'b0, 1'b0);
    send_item(16'd7, 1'b1, 1'b0);
    send_item(16'h8000, 1'b0, 1'b1);
    repeat (3) send_item(16'h8000, 1'b1, 1'b0);
    repeat (3) send_item(16'd0, 1'b1, 1'b0);
  endtask

  // Zero threshold and a hold of zero, each written with stray upper bits,
  // plus a write to an index that maps to no register.
  task automatic test_register_extremes();
    wait_idle();
    cfg_write(REG_THRESHOLD_SQUARED, 32'h8000_0000);
    cfg_write(REG_HOLD_FRAMES, 32'hFFFF_FF00);
    cfg_write(REG_HOLD_FRAMES + CFG_INDEX_W'($urandom_range(1, 254)), 32'hFFFF_FFFF);
    cfg_done();
    send_item(16'd0, 1'b1, 1'b0);
    send_item(16'd1, 1'b1, 1'b0);
    send_item(16'd0, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'd0, 1'b1, 1'b0);
  endtask

  // A full window of the largest magnitude gives the widest energy sum, just
  // above the threshold; the zero samples after it would pull the mean below
  // the threshold if they were counted.
  task automatic test_overlong_window();
    wait_idle();
    cfg_write(REG_THRESHOLD_SQUARED, 32'h3FFF_FFFF);
    cfg_write(REG_HOLD_FRAMES, 32'd1);
    cfg_done();
    repeat (WIN_ITEMS) send_item(16'h8000, 1'b0, 1'b0);
    repeat (3) send_item(16'd0, 1'b0, 1'b0);
    send_item(16'd0, 1'b1, 1'b0);
    send_item(16'd0, 1'b1, 1'b0);
  endtask

  // With a long hold the counter climbs frame by frame until the flip.
  task automatic test_long_hold();
    wait_idle();
    cfg_write(REG_THRESHOLD_SQUARED, 32'd0);
    cfg_write(REG_HOLD_FRAMES, 32'd40);
    cfg_done();
    send_item(16'd0, 1'b1, 1'b1);
    send_item(16'd0, 1'b1, 1'b0);
    repeat (40) send_item(16'($urandom_range(1, 65535)), 1'b1, 1'b0);
    send_item(16'd0, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned  level;
    int unsigned  thr;
    int unsigned  hold;
    int           sent;
    int           len;
    int           i;
    int           phase;
    sample_kind_e kind;
    logic [15:0]  fixed;
    logic [15:0]  smp;
    bit           noisy;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          thr = THRESHOLD_SQUARED_RESET; hold = HOLD_FRAMES_RESET; level = 1600;
        end
        1: begin
          thr = 0; hold = 1; level = 3;
        end
        2: begin
          thr = 32'h4000_0000; hold = 255; level = 32768;
        end
        5: begin
          level = $urandom_range(1, 32768);
          thr = level * level + $urandom_range(0, 2 * level);
          if (thr > 32'h4000_0000) thr = 32'h4000_0000;
          hold = $urandom_range(1, 12);
        end
        default: begin
          level = $urandom_range(1, 32768);
          thr = level * level;
          hold = $urandom_range(1, 6);
        end
      endcase
      wait_idle();
      cfg_write(REG_THRESHOLD_SQUARED, thr);
      cfg_write(REG_HOLD_FRAMES, hold);
      cfg_done();
      tx_burst = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        kind  = sample_kind_e'($urandom_range(0, 4));
        fixed = near_sample(level);
        noisy = ($urandom_range(0, 9) == 0);
        // Now and then let the block run completely dry before a frame.
        if ($urandom_range(0, 29) == 0) wait_idle();
        if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
        for (i = 0; i < len; i++) begin
          if (noisy) begin
            send_item(16'($urandom), (i == len - 1) || ($urandom_range(0, 3) == 0),
                      ($urandom_range(0, 7) == 0));
          end else if ($urandom_range(0, 39) == 0) begin
            // A frame cut short by the end of the clip.
            send_item(16'($urandom), 1'($urandom_range(0, 1)), 1'b1);
          end else begin
            case (kind)
              SK_ZERO:    smp = '0;
              SK_NEAR:    smp = near_sample(level);
              SK_FULL:    smp = 16'($urandom);
              SK_EXTREME: smp = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
              default:    smp = fixed;
            endcase
            send_item(smp, (i == len - 1), 1'b0);
          end
          sent++;
        end
      end
    end
  endtask

  // Result side: random stalls with occasional stretches of full speed.
  initial begin : accept_results
    int unsigned stall;
    bit          rx_burst;
    rx_burst = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_levels
    level_t exp_lv;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_levels.size() == 0) begin
        $error("result item with none expected: m_tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        exp_lv = expected_levels.pop_front();
        if (m_tdata[0] !== exp_lv.mouth_open) begin
          $error("mouth_open: expected %0d, actual %0d", exp_lv.mouth_open, m_tdata[0]);
          mismatch_count++;
        end
        if (m_tdata[1] !== exp_lv.above_threshold) begin
          $error("above_threshold: expected %0d, actual %0d",
                 exp_lv.above_threshold, m_tdata[1]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : run_tests
    int waited;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    energy_limit  = THRESHOLD_SQUARED_RESET;
    hold_need     = HOLD_FRAMES_RESET;
    window_energy = '0;
    window_count  = '0;
    held_open     = 1'b0;
    hold_run      = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_levels();
    test_register_extremes();
    test_overlong_window();
    test_long_hold();
    test_random_traffic();

    s_tvalid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (expected_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (IDLE_SETTLE) @(posedge clk);
    if (expected_levels.size() != 0) begin
      $error("%0d result items never arrived", expected_levels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
design/wevd_pkg.sv
design/windowed_energy_voice_detector_core.sv
sim/tb_top.sv
